FILE: rtl/pidv_pkg.sv
// ----------------------------------------------------------------------------
// pidv_pkg: shared types and constants of the variable-interval PID block
// Operand widths, fixed-point limits, register indexes and unit status.
// ----------------------------------------------------------------------------
package pidv_pkg;

    localparam int OPND_W     = 32;   // narrow operand of the multiplier and divider
    localparam int GAIN_W     = 32;
    localparam int GAP_W      = 32;
    localparam int DRIVE_W    = 32;
    localparam int INTEG_W    = 48;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_W     = 16;   // fraction bits of the Q16.16 gains
    localparam int TERM_SHIFT = 60;   // derivative term clamps at +-2^60

    localparam logic [OPND_W-1:0] US_PER_SECOND = 32'd1000000;
    localparam logic [GAP_W-1:0]  GAP_RESET     = 32'd10000;

    localparam logic [ACC_W-1:0] INTEG_MAX_EXT = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] INTEG_MIN_EXT = 64'hFFFF_8000_0000_0000;
    localparam logic [ACC_W-1:0] TERM_LIMIT    = 64'h1000_0000_0000_0000;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P   = 3'd0,
        CFG_GAIN_I   = 3'd1,
        CFG_GAIN_D   = 3'd2,
        CFG_SETPOINT = 3'd3,
        CFG_MAX_GAP  = 3'd4
    } cfg_index_t;

    // Handshake status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

FILE: rtl/pidv_mul.sv
// ----------------------------------------------------------------------------
// pidv_mul: bit-serial unsigned multiplier
// Shift-and-add over the 32-bit operand, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pidv_mul #(
    parameter int MC_W = 48
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [MC_W-1:0]                         mcand,
    input  logic [pidv_pkg::OPND_W-1:0]             mplier,
    output pidv_pkg::unit_status_t                  status,
    output logic [MC_W+pidv_pkg::OPND_W-1:0]        product
);
    import pidv_pkg::*;

    localparam int CNT_W = $clog2(OPND_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MC_W-1:0]   mcand_reg;
    logic [MC_W-1:0]   hi_reg;
    logic [OPND_W-1:0] lo_reg;
    logic [MC_W:0]     sum;

    // The low register holds the unused multiplier bits and collects the
    // product bits that drop out of the partial sum.
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OPND_W);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end else if (busy_reg) begin
            hi_reg <= sum[MC_W:1];
            lo_reg <= {sum[0], lo_reg[OPND_W-1:1]};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = {hi_reg, lo_reg};

endmodule

FILE: rtl/pidv_div.sv
// ----------------------------------------------------------------------------
// pidv_div: bit-serial restoring divider
// Unsigned wide dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidv_div #(
    parameter int DD_W = 80
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [DD_W-1:0]                  dividend,
    input  logic [pidv_pkg::OPND_W-1:0]      divisor,
    input  logic [$clog2(DD_W+1)-1:0]        steps,
    output pidv_pkg::unit_status_t           status,
    output logic [DD_W-1:0]                  quotient
);
    import pidv_pkg::*;

    localparam int CNT_W = $clog2(DD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OPND_W-1:0] dvs_reg;
    logic [OPND_W-1:0] rem_reg;
    logic [DD_W-1:0]   quo_reg;
    logic [OPND_W:0]   shifted;
    logic [OPND_W+1:0] trial;
    logic              fits;

    // The dividend arrives left aligned, so its top bit feeds the remainder
    // first and the quotient fills in from the bottom.
    assign shifted = {rem_reg, quo_reg[DD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits    = !trial[OPND_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = steps;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[OPND_W-1:0] : shifted[OPND_W-1:0];
            quo_reg <= {quo_reg[DD_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

FILE: rtl/pid_controller_variable_dt.sv
// ----------------------------------------------------------------------------
// pid_controller_variable_dt: PID controller with a variable sample interval
// Sequencer, controller state and configuration around a shared bit-serial
// multiplier and divider.
// ----------------------------------------------------------------------------
// Each transaction on the s_ side carries a measured value and the
// microseconds since the previous sample; one transaction on the m_ side
// returns the saturated drive value, with tuser set when the sample was
// skipped (gap of zero or above max_gap_us), in which case the previous
// drive is repeated and no state changes. A full update runs five
// multiplications of 32 serial steps each, the derivative division of
// DATA_WIDTH+21 steps and the integral scaling division of 80 steps at the
// default width on the one multiplier and one divider, in sequence. The
// next sample is taken once the result sits in the output register, even
// if it has not been collected. Configuration writes are accepted at any
// time, but the gains are read throughout an update, so writes
// are meant to happen while no sample is in progress.
// ----------------------------------------------------------------------------
module pid_controller_variable_dt #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // s_tdata: measured_value [DATA_WIDTH-1:0], elapsed_us [DATA_WIDTH+31:DATA_WIDTH]
    input  logic [((DATA_WIDTH+pidv_pkg::GAP_W+7)/8)*8-1:0] s_tdata,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // m_tdata: drive_value [31:0]
    output logic [pidv_pkg::DRIVE_W-1:0]                 m_tdata,
    // m_tuser: skipped [0]
    output logic                                         m_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [pidv_pkg::CFG_IDX_W-1:0]               cfg_index,
    input  logic [pidv_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import pidv_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int ERR_W  = DW + 1;
    localparam int DIFF_W = DW + 2;
    localparam int NUMD_W = DW + 21;
    localparam int MC_W   = (NUMD_W > INTEG_W) ? NUMD_W : INTEG_W;
    localparam int PR_W   = MC_W + OPND_W;
    localparam int DCNT_W = $clog2(PR_W + 1);

    localparam logic [PR_W-1:0] TERM_LIM_PR = PR_W'(1) << TERM_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DMUL,
        ST_DDIV,
        ST_DGAIN,
        ST_PGAIN,
        ST_IMUL,
        ST_ISAT,
        ST_IGAIN,
        ST_IDIV,
        ST_DRIVE,
        ST_FINISH
    } state_t;

    // Configuration.
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [DW-1:0]     setpoint_reg;
    logic [GAP_W-1:0]  max_gap_reg;

    // Control and controller state.
    state_t             state_reg, state_next;
    logic               mul_start_reg, mul_start_next;
    logic               div_start_reg, div_start_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [DRIVE_W-1:0] m_tdata_reg, m_tdata_next;
    logic               m_tuser_reg, m_tuser_next;
    logic [ERR_W-1:0]   last_error_reg, last_error_next;
    logic [INTEG_W-1:0] integral_reg, integral_next;
    logic [DRIVE_W-1:0] last_drive_reg, last_drive_next;

    // Per-sample working registers.
    logic [MC_W-1:0]    mul_a_reg, mul_a_next;
    logic [OPND_W-1:0]  mul_b_reg, mul_b_next;
    logic [PR_W-1:0]    div_a_reg, div_a_next;
    logic [OPND_W-1:0]  div_b_reg, div_b_next;
    logic [DCNT_W-1:0]  div_n_reg, div_n_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               neg_reg, neg_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [INTEG_W-1:0] integ_new_reg, integ_new_next;
    logic [DRIVE_W-1:0] res_drive_reg, res_drive_next;
    logic               res_skip_reg, res_skip_next;

    unit_status_t       mul_stat, div_stat;
    logic [PR_W-1:0]    mul_prod;
    logic [PR_W-1:0]    div_quo;

    // Combinational helpers.
    logic [DW-1:0]      meas_in;
    logic [GAP_W-1:0]   gap_in;
    logic               skip_in;
    logic [ERR_W-1:0]   err_in;
    logic [DIFF_W-1:0]  diff_in;
    logic [DIFF_W-1:0]  diff_mag;
    logic [ERR_W-1:0]   err_mag;
    logic [GAIN_W-1:0]  gain_p_mag, gain_i_mag, gain_d_mag;
    logic [ACC_W-1:0]   dterm_mag;
    logic [ACC_W-1:0]   integ_ext;
    logic [ACC_W-1:0]   integ_sum;
    logic [INTEG_W-1:0] integ_sat;
    logic [INTEG_W-1:0] integ_mag;
    logic               drive_ovf;
    logic [DRIVE_W-1:0] drive_sat;
    logic               out_load;

    assign meas_in = s_tdata[DW-1:0];
    assign gap_in  = s_tdata[DW+GAP_W-1:DW];
    assign skip_in = (gap_in == '0) || (gap_in > max_gap_reg);
    assign err_in  = {meas_in[DW-1], meas_in} - {setpoint_reg[DW-1], setpoint_reg};
    assign diff_in = {err_in[ERR_W-1], err_in} - {last_error_reg[ERR_W-1], last_error_reg};
    assign diff_mag = diff_in[DIFF_W-1] ? (~diff_in + DIFF_W'(1)) : diff_in;
    assign err_mag  = err_reg[ERR_W-1] ? (~err_reg + ERR_W'(1)) : err_reg;

    assign gain_p_mag = gain_p_reg[GAIN_W-1] ? (~gain_p_reg + GAIN_W'(1)) : gain_p_reg;
    assign gain_i_mag = gain_i_reg[GAIN_W-1] ? (~gain_i_reg + GAIN_W'(1)) : gain_i_reg;
    assign gain_d_mag = gain_d_reg[GAIN_W-1] ? (~gain_d_reg + GAIN_W'(1)) : gain_d_reg;

    // A derivative term beyond 2^60 only occurs when the drive saturates anyway.
    assign dterm_mag = (mul_prod > TERM_LIM_PR) ? TERM_LIMIT : mul_prod[ACC_W-1:0];

    assign integ_ext = {{(ACC_W-INTEG_W){integral_reg[INTEG_W-1]}}, integral_reg};
    assign integ_sum = neg_reg ? (integ_ext - mul_prod[ACC_W-1:0])
                               : (integ_ext + mul_prod[ACC_W-1:0]);
    always_comb begin
        if ($signed(integ_sum) > $signed(INTEG_MAX_EXT)) begin
            integ_sat = INTEG_MAX_EXT[INTEG_W-1:0];
        end else if ($signed(integ_sum) < $signed(INTEG_MIN_EXT)) begin
            integ_sat = INTEG_MIN_EXT[INTEG_W-1:0];
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end
    assign integ_mag = integ_new_reg[INTEG_W-1] ? (~integ_new_reg + INTEG_W'(1))
                                                : integ_new_reg;

    // The arithmetic shift by the fraction width floors, matching the Q16.16
    // rounding of negative sums.
    assign drive_ovf = acc_reg[ACC_W-1:FRAC_W+DRIVE_W-1]
                       != {(ACC_W-FRAC_W-DRIVE_W+1){acc_reg[ACC_W-1]}};
    assign drive_sat = drive_ovf ? (acc_reg[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX)
                                 : acc_reg[FRAC_W+DRIVE_W-1:FRAC_W];

    assign out_load = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        mul_start_next  = 1'b0;
        div_start_next  = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        last_drive_next = last_drive_reg;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        div_a_next      = div_a_reg;
        div_b_next      = div_b_reg;
        div_n_next      = div_n_reg;
        gap_next        = gap_reg;
        err_next        = err_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        integ_new_next  = integ_new_reg;
        res_drive_next  = res_drive_reg;
        res_skip_next   = res_skip_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    gap_next = gap_in;
                    err_next = err_in;
                    if (skip_in) begin
                        res_drive_next = last_drive_reg;
                        res_skip_next  = 1'b1;
                        state_next     = ST_FINISH;
                    end else begin
                        mul_a_next     = {{(MC_W-DIFF_W){1'b0}}, diff_mag};
                        mul_b_next     = US_PER_SECOND;
                        neg_next       = diff_in[DIFF_W-1];
                        mul_start_next = 1'b1;
                        state_next     = ST_DMUL;
                    end
                end
            end
            ST_DMUL: begin
                if (mul_stat.done) begin
                    div_a_next     = {mul_prod[NUMD_W-1:0], {(PR_W-NUMD_W){1'b0}}};
                    div_b_next     = gap_reg;
                    div_n_next     = DCNT_W'(NUMD_W);
                    div_start_next = 1'b1;
                    state_next     = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (div_stat.done) begin
                    mul_a_next     = {{(MC_W-NUMD_W){1'b0}}, div_quo[NUMD_W-1:0]};
                    mul_b_next     = gain_d_mag;
                    neg_next       = neg_reg ^ gain_d_reg[GAIN_W-1];
                    mul_start_next = 1'b1;
                    state_next     = ST_DGAIN;
                end
            end
            ST_DGAIN: begin
                if (mul_stat.done) begin
                    acc_next       = neg_reg ? (~dterm_mag + ACC_W'(1)) : dterm_mag;
                    mul_a_next     = {{(MC_W-ERR_W){1'b0}}, err_mag};
                    mul_b_next     = gain_p_mag;
                    neg_next       = err_reg[ERR_W-1] ^ gain_p_reg[GAIN_W-1];
                    mul_start_next = 1'b1;
                    state_next     = ST_PGAIN;
                end
            end
            ST_PGAIN: begin
                if (mul_stat.done) begin
                    acc_next       = neg_reg ? (acc_reg - mul_prod[ACC_W-1:0])
                                             : (acc_reg + mul_prod[ACC_W-1:0]);
                    mul_a_next     = {{(MC_W-ERR_W){1'b0}}, err_mag};
                    mul_b_next     = gap_reg;
                    neg_next       = err_reg[ERR_W-1];
                    mul_start_next = 1'b1;
                    state_next     = ST_IMUL;
                end
            end
            ST_IMUL: begin
                if (mul_stat.done) begin
                    integ_new_next = integ_sat;
                    state_next     = ST_ISAT;
                end
            end
            ST_ISAT: begin
                mul_a_next     = {{(MC_W-INTEG_W){1'b0}}, integ_mag};
                mul_b_next     = gain_i_mag;
                neg_next       = integ_new_reg[INTEG_W-1] ^ gain_i_reg[GAIN_W-1];
                mul_start_next = 1'b1;
                state_next     = ST_IGAIN;
            end
            ST_IGAIN: begin
                if (mul_stat.done) begin
                    div_a_next     = mul_prod;
                    div_b_next     = US_PER_SECOND;
                    div_n_next     = DCNT_W'(PR_W);
                    div_start_next = 1'b1;
                    state_next     = ST_IDIV;
                end
            end
            ST_IDIV: begin
                if (div_stat.done) begin
                    acc_next   = neg_reg ? (acc_reg - div_quo[ACC_W-1:0])
                                         : (acc_reg + div_quo[ACC_W-1:0]);
                    state_next = ST_DRIVE;
                end
            end
            ST_DRIVE: begin
                res_drive_next  = drive_sat;
                res_skip_next   = 1'b0;
                last_drive_next = drive_sat;
                last_error_next = err_reg;
                integral_next   = integ_new_reg;
                state_next      = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_drive_reg;
                    m_tuser_next  = res_skip_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
            last_error_reg <= '0;
            integral_reg   <= '0;
            last_drive_reg <= '0;
        end else begin
            state_reg      <= state_next;
            mul_start_reg  <= mul_start_next;
            div_start_reg  <= div_start_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            last_drive_reg <= last_drive_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        div_a_reg     <= div_a_next;
        div_b_reg     <= div_b_next;
        div_n_reg     <= div_n_next;
        gap_reg       <= gap_next;
        err_reg       <= err_next;
        neg_reg       <= neg_next;
        acc_reg       <= acc_next;
        integ_new_reg <= integ_new_next;
        res_drive_reg <= res_drive_next;
        res_skip_reg  <= res_skip_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            setpoint_reg <= '0;
            max_gap_reg  <= GAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GAIN_P:   gain_p_reg   <= cfg_data;
                CFG_GAIN_I:   gain_i_reg   <= cfg_data;
                CFG_GAIN_D:   gain_d_reg   <= cfg_data;
                CFG_SETPOINT: setpoint_reg <= cfg_data[DW-1:0];
                CFG_MAX_GAP:  max_gap_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    pidv_mul #(
        .MC_W(MC_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .status  (mul_stat),
        .product (mul_prod)
    );

    pidv_div #(
        .DD_W(PR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .steps    (div_n_reg),
        .status   (div_stat),
        .quotient (div_quo)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign cfg_ready = 1'b1;

    // The multiplier and divider are used strictly one after the other.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider busy at the same time");

    // A finished multiplication is only reported while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> (state_reg == ST_DMUL || state_reg == ST_DGAIN ||
                           state_reg == ST_PGAIN || state_reg == ST_IMUL ||
                           state_reg == ST_IGAIN))
        else $error("multiplier result arrived outside a wait state");

    // Every result leaves with the drive value that the controller now holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_tdata == last_drive_reg))
        else $error("result drive differs from the held drive value");

endmodule
